### rtl/bdq_pkg.sv
// shared constants, operation codes and control types for the bounded deque
`default_nettype none

package bdq_pkg;

    // storage geometry
    localparam int MAX_DEPTH = 1024;
    localparam int IDX_W     = $clog2(MAX_DEPTH);
    localparam int CNT_W     = 11;
    localparam int CAP_W     = 11;
    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;

    localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(1024);
    localparam logic [CAP_W-1:0]  CAP_MAX    = CAP_W'(MAX_DEPTH);
    localparam logic [DATA_W-1:0] EMPTY_WORD = '1;

    // operation codes of an input word
    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_REAR  = 3'd1,
        OP_DEL_FRONT = 3'd2,
        OP_DEL_REAR  = 3'd3,
        OP_QUERY     = 3'd4
    } t_op;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic read;
    } t_dp_cmd;

    // ring index step forward with wrap
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        r = (32'(i) + 32'd1 >= 32'(MAX_DEPTH)) ? '0 : i + IDX_W'(1);
        return r;
    endfunction

    // ring index step back with wrap
    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        r = (i == '0) ? IDX_W'(MAX_DEPTH - 1) : i - IDX_W'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/bdq_ctrl.sv
// sequencing state machine: accept, execute, read back, respond
`default_nettype none

module bdq_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output bdq_pkg::t_dp_cmd     o_cmd
);
    import bdq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: n_state = S_READ;
            S_READ: n_state = S_RESP;
            S_RESP: begin
                if (!i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // handshake and datapath commands
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_RESP);
    assign o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec  = (r_state == S_EXEC);
    assign o_cmd.read  = (r_state == S_READ);

endmodule

`default_nettype wire

### rtl/bdq_datapath.sv
// ring buffer storage, indices, count, capacity and result registers
`default_nettype none

module bdq_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bdq_pkg::t_dp_cmd              i_cmd,
    input  wire logic                          i_cfg_we,
    input  wire logic [bdq_pkg::CAP_W-1:0]     i_cfg_wdata,
    input  wire logic [bdq_pkg::OP_W-1:0]      i_operation,
    input  wire logic signed [bdq_pkg::DATA_W-1:0] i_value,
    output logic                               o_ok,
    output logic signed [bdq_pkg::DATA_W-1:0]  o_front_value,
    output logic signed [bdq_pkg::DATA_W-1:0]  o_rear_value,
    output logic                               o_is_empty,
    output logic                               o_is_full,
    output logic [bdq_pkg::CNT_W-1:0]          o_count
);
    import bdq_pkg::*;

    logic [DATA_W-1:0] r_mem [MAX_DEPTH];

    t_op               r_op;
    logic [DATA_W-1:0] r_value;
    logic [IDX_W-1:0]  r_front, n_front;
    logic [IDX_W-1:0]  r_rear, n_rear;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CAP_W-1:0]  r_cap;
    logic              r_ok, n_ok;
    logic [DATA_W-1:0] r_rd_front, r_rd_rear;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [CAP_W-1:0]  eff_cap;
    logic              full, empty;

    // capacity saturates at the storage depth
    assign eff_cap = (r_cap > CAP_MAX) ? CAP_MAX : r_cap;
    assign full    = (r_count >= CNT_W'(eff_cap));
    assign empty   = (r_count == '0);

    // operation decode
    always_comb begin
        n_front = r_front;
        n_rear  = r_rear;
        n_count = r_count;
        n_ok    = 1'b0;
        wr_en   = 1'b0;
        wr_addr = r_rear;
        case (r_op)
            OP_INS_FRONT: begin
                if (!full) begin
                    n_front = idx_dec(r_front);
                    wr_addr = n_front;
                    wr_en   = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    n_ok    = 1'b1;
                end
            end
            OP_INS_REAR: begin
                if (!full) begin
                    wr_addr = r_rear;
                    wr_en   = 1'b1;
                    n_rear  = idx_inc(r_rear);
                    n_count = r_count + CNT_W'(1);
                    n_ok    = 1'b1;
                end
            end
            OP_DEL_FRONT: begin
                if (!empty) begin
                    n_front = idx_inc(r_front);
                    n_count = r_count - CNT_W'(1);
                    n_ok    = 1'b1;
                end
            end
            OP_DEL_REAR: begin
                if (!empty) begin
                    n_rear  = idx_dec(r_rear);
                    n_count = r_count - CNT_W'(1);
                    n_ok    = 1'b1;
                end
            end
            OP_QUERY: n_ok = 1'b1;
            default: n_ok = 1'b0;
        endcase
    end

    // control state: indices, count, capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_rear  <= '0;
            r_count <= '0;
            r_cap   <= CAP_RESET;
            r_ok    <= 1'b0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_wdata;
            if (i_cmd.exec) begin
                r_front <= n_front;
                r_rear  <= n_rear;
                r_count <= n_count;
                r_ok    <= n_ok;
            end
        end
    end

    // input word capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= t_op'(i_operation);
            r_value <= i_value;
        end
    end

    // entry store: one write port, front and rear read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) r_mem[wr_addr] <= r_value;
        if (i_cmd.read) begin
            r_rd_front <= r_mem[r_front];
            r_rd_rear  <= r_mem[idx_dec(r_rear)];
        end
    end

    // result word
    assign o_ok          = r_ok;
    assign o_is_empty    = empty;
    assign o_is_full     = full;
    assign o_count       = r_count;
    assign o_front_value = empty ? EMPTY_WORD : r_rd_front;
    assign o_rear_value  = empty ? EMPTY_WORD : r_rd_rear;

endmodule

`default_nettype wire

### rtl/bounded_double_ended_queue.sv
// top level of the bounded double-ended queue
`default_nettype none

// Bounded deque of 32-bit words held in a 1024-entry ring buffer. Each input
// word carries one operation (insert front, insert rear, delete front, delete
// rear, query) and produces one result word with the outcome, the front and
// rear entries (-1 when empty), empty and full flags and the count. An item
// passes from acceptance to its result through these steps: the word is
// taken, the indices are updated and the store is written, the front and
// rear entries are read into registers, and the result is offered and held
// until taken; the next word is accepted in the cycle after the result
// leaves. The capacity register (reset 1024, values above 1024 act as 1024)
// may be rewritten only while no word is in flight and never clears the
// deque. The store needs no clearing pass after reset.
module bounded_double_ended_queue (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [bdq_pkg::OP_W-1:0]          i_operation,
    input  wire logic signed [bdq_pkg::DATA_W-1:0] i_value,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic                                   o_ok,
    output logic signed [bdq_pkg::DATA_W-1:0]      o_front_value,
    output logic signed [bdq_pkg::DATA_W-1:0]      o_rear_value,
    output logic                                   o_is_empty,
    output logic                                   o_is_full,
    output logic [bdq_pkg::CNT_W-1:0]              o_count,
    input  wire logic                              i_cfg_we,
    input  wire logic [bdq_pkg::CAP_W-1:0]         i_cfg_wdata
);
    import bdq_pkg::*;

    t_dp_cmd cmd;

    // sequencer
    bdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // storage and result
    bdq_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .o_ok          (o_ok),
        .o_front_value (o_front_value),
        .o_rear_value  (o_rear_value),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full),
        .o_count       (o_count)
    );

    // one word in flight: never offer a result while taking input
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out_valid && !o_in_stall))
        else $error("result offered while input open");

    // an accepted word is answered once it has passed the execute and read states
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> ##3 o_out_valid)
        else $error("result not offered on time");

    // count never exceeds the storage depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(o_count) <= MAX_DEPTH)
        else $error("count beyond storage depth");

endmodule

`default_nettype wire

### test/tb_bounded_double_ended_queue.sv
`timescale 1ns / 1ps
// self-checking testbench for the bounded deque: directed and random words against a shadow deque
module tb_bounded_double_ended_queue;
    import bdq_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 11;
    localparam int MAX_GAP       = 13;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_WORDS  = 680;
    localparam int RANDOM_PHASES = 10;
    localparam int MAX_REPORTS   = 40;
    localparam int SAT_FILL      = 12;

    // codes the block leaves unused
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam logic [CAP_W-1:0]  CAP_ALL_ONES = '1;
    localparam logic [DATA_W-1:0] WORD_MIN     = 32'h8000_0000;
    localparam logic [DATA_W-1:0] WORD_MAX     = 32'h7FFF_FFFF;

    // expected contents of one result word
    typedef struct {
        logic              ok;
        logic [DATA_W-1:0] front;
        logic [DATA_W-1:0] rear;
        logic              empty;
        logic              full;
        logic [CNT_W-1:0]  count;
    } t_deque_status;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_stall;
    logic [OP_W-1:0]          i_operation = '0;
    logic signed [DATA_W-1:0] i_value     = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic                     o_ok;
    logic signed [DATA_W-1:0] o_front_value;
    logic signed [DATA_W-1:0] o_rear_value;
    logic                     o_is_empty;
    logic                     o_is_full;
    logic [CNT_W-1:0]         o_count;
    logic                     i_cfg_we    = 1'b0;
    logic [CAP_W-1:0]         i_cfg_wdata = '0;

    // shadow deque
    logic [DATA_W-1:0] shadow_store [MAX_DEPTH];
    logic [IDX_W-1:0]  shadow_head  = '0;
    logic [IDX_W-1:0]  shadow_tail  = '0;
    logic [CNT_W-1:0]  shadow_count = '0;
    logic [CAP_W-1:0]  shadow_cap   = CAP_RESET;

    t_deque_status expected_status[$];

    bit in_gaps  = 1'b1;
    bit out_gaps = 1'b1;
    bit growing  = 1'b1;
    int out_hold = 0;

    int fail_count    = 0;
    int words_sent    = 0;
    int refused_words = 0;
    int results_seen  = 0;
    int cap_writes    = 0;
    int cycle_count   = 0;

    bounded_double_ended_queue u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_ok          (o_ok),
        .o_front_value (o_front_value),
        .o_rear_value  (o_rear_value),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full),
        .o_count       (o_count),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // clock
    always #CLK_HALF i_clk = ~i_clk;

    // ring index steps with wrap at the store depth
    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
        return (int'(i) == MAX_DEPTH - 1) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(MAX_DEPTH - 1) : i - 1'b1;
    endfunction

    // capacity above the store depth acts as the store depth
    function automatic int effective_capacity();
        return (int'(shadow_cap) > MAX_DEPTH) ? MAX_DEPTH : int'(shadow_cap);
    endfunction

    // apply one operation to the shadow deque and return the status it reports
    function automatic t_deque_status apply_operation(input logic [OP_W-1:0] op,
                                                      input logic [DATA_W-1:0] val);
        t_deque_status st;
        logic          was_full;
        logic          was_empty;
        was_full  = int'(shadow_count) >= effective_capacity();
        was_empty = (shadow_count == '0);
        st.ok     = 1'b0;
        case (op)
            OP_INS_FRONT: begin
                if (!was_full) begin
                    shadow_head               = ring_prev(shadow_head);
                    shadow_store[shadow_head] = val;
                    shadow_count              = shadow_count + 1'b1;
                    st.ok                     = 1'b1;
                end
            end
            OP_INS_REAR: begin
                if (!was_full) begin
                    shadow_store[shadow_tail] = val;
                    shadow_tail               = ring_next(shadow_tail);
                    shadow_count              = shadow_count + 1'b1;
                    st.ok                     = 1'b1;
                end
            end
            OP_DEL_FRONT: begin
                if (!was_empty) begin
                    shadow_head  = ring_next(shadow_head);
                    shadow_count = shadow_count - 1'b1;
                    st.ok        = 1'b1;
                end
            end
            OP_DEL_REAR: begin
                if (!was_empty) begin
                    shadow_tail  = ring_prev(shadow_tail);
                    shadow_count = shadow_count - 1'b1;
                    st.ok        = 1'b1;
                end
            end
            OP_QUERY: begin
                st.ok = 1'b1;
            end
            default: begin
                st.ok = 1'b0;
            end
        endcase
        st.empty = (shadow_count == '0);
        st.full  = int'(shadow_count) >= effective_capacity();
        st.count = shadow_count;
        st.front = st.empty ? EMPTY_WORD : shadow_store[shadow_head];
        st.rear  = st.empty ? EMPTY_WORD : shadow_store[ring_prev(shadow_tail)];
        if (!st.ok) refused_words++;
        return st;
    endfunction

    // data word with the extremes drawn often
    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(11, 0))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    // random walk between empty and full with some noise
    function automatic logic [OP_W-1:0] pick_random_op();
        int roll;
        bit inserting;
        roll = $urandom_range(99, 0);
        if (int'(shadow_count) >= effective_capacity()) growing = 1'b0;
        else if (shadow_count == '0) growing = 1'b1;
        if (roll < 4) return OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        if (roll < 10) return OP_QUERY;
        if (roll < 18) return OP_W'($urandom_range(OP_DEL_REAR, OP_INS_FRONT));
        inserting = growing ? (roll < 84) : (roll >= 84);
        if (inserting) return $urandom_range(1, 0) ? OP_INS_FRONT : OP_INS_REAR;
        return $urandom_range(1, 0) ? OP_DEL_FRONT : OP_DEL_REAR;
    endfunction

    function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
        if (got !== want) begin
            if (fail_count < MAX_REPORTS)
                $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // compare one result word with the oldest expectation
    function automatic void check_result();
        t_deque_status want;
        results_seen++;
        if (expected_status.size() == 0) begin
            if (fail_count < MAX_REPORTS)
                $error("result word with no expectation pending");
            fail_count++;
        end else begin
            want = expected_status.pop_front();
            check_field("ok", want.ok, o_ok);
            check_field("front_value", want.front, o_front_value);
            check_field("rear_value", want.rear, o_rear_value);
            check_field("is_empty", want.empty, o_is_empty);
            check_field("is_full", want.full, o_is_full);
            check_field("count", want.count, o_count);
        end
    endfunction

    // result side: take words and, when output gaps are on, stall a random number of cycles after each
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                check_result();
                out_hold = out_gaps ? $urandom_range(MAX_GAP, 0) : 0;
                i_out_stall <= (out_hold != 0);
            end else if (out_hold != 0) begin
                out_hold--;
                i_out_stall <= (out_hold != 0);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results pending", cycle_count,
                   expected_status.size());
            $display("tb_bounded_double_ended_queue: FAIL");
            $finish;
        end
    end

    // send one word; valid stays high so back-to-back words need no dip
    task automatic send_word(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val);
        int gap;
        gap = in_gaps ? $urandom_range(MAX_GAP, 0) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_value     <= val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_status.push_back(apply_operation(op, val));
        words_sent++;
    endtask

    // drop valid and let every outstanding word come back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_status.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        shadow_cap  = cap;
        cap_writes++;
    endtask

    // refused deletes, query and unused codes on the empty deque after reset
    task automatic test_empty_deque();
        in_gaps  = 1'b1;
        out_gaps = 1'b1;
        send_word(OP_QUERY, rand_word());
        send_word(OP_DEL_FRONT, rand_word());
        send_word(OP_DEL_REAR, rand_word());
        for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++)
            send_word(OP_W'(c), rand_word());
    endtask

    // capacities above the store depth on a partly filled deque, then drain
    task automatic test_saturated_capacity();
        in_gaps  = 1'b0;
        out_gaps = 1'b0;
        write_capacity(CAP_ALL_ONES);
        for (int n = 0; n < SAT_FILL; n++)
            send_word($urandom_range(1, 0) ? OP_INS_FRONT : OP_INS_REAR, rand_word());
        send_word(OP_QUERY, rand_word());
        write_capacity(CAP_MAX + 1'b1);
        send_word(OP_INS_FRONT, rand_word());
        out_gaps = 1'b1;
        for (int n = 0; n <= SAT_FILL; n++)
            send_word($urandom_range(1, 0) ? OP_DEL_FRONT : OP_DEL_REAR, rand_word());
        send_word(OP_DEL_FRONT, rand_word());
        write_capacity(CAP_RESET);
    endtask

    // every operation with extreme data words
    task automatic test_basic_operations();
        in_gaps  = 1'b1;
        out_gaps = 1'b1;
        send_word(OP_INS_FRONT, WORD_MIN);
        send_word(OP_INS_REAR, WORD_MAX);
        send_word(OP_INS_FRONT, '1);
        send_word(OP_INS_REAR, '0);
        send_word(OP_QUERY, rand_word());
        send_word(OP_SPARE_HI, rand_word());
        send_word(OP_DEL_FRONT, rand_word());
        send_word(OP_DEL_REAR, rand_word());
        send_word(OP_DEL_REAR, rand_word());
        send_word(OP_DEL_FRONT, rand_word());
        send_word(OP_INS_REAR, rand_word());
        send_word(OP_DEL_FRONT, rand_word());
    endtask

    // capacity of one and of zero
    task automatic test_small_capacity();
        write_capacity(CAP_W'(1));
        send_word(OP_INS_REAR, rand_word());
        send_word(OP_INS_FRONT, rand_word());
        send_word(OP_INS_REAR, rand_word());
        send_word(OP_QUERY, rand_word());
        send_word(OP_DEL_FRONT, rand_word());
        send_word(OP_DEL_REAR, rand_word());
        write_capacity('0);
        send_word(OP_INS_FRONT, rand_word());
        send_word(OP_INS_REAR, rand_word());
        send_word(OP_QUERY, rand_word());
    endtask

    // capacity dropped below the count keeps the entries and refuses inserts
    task automatic test_capacity_below_count();
        write_capacity(CAP_W'(8));
        for (int n = 0; n < 6; n++)
            send_word(n[0] ? OP_INS_FRONT : OP_INS_REAR, rand_word());
        write_capacity(CAP_W'(3));
        send_word(OP_INS_FRONT, rand_word());
        send_word(OP_INS_REAR, rand_word());
        send_word(OP_QUERY, rand_word());
        for (int n = 0; n < 3; n++)
            send_word(OP_DEL_FRONT, rand_word());
        send_word(OP_DEL_REAR, rand_word());
        send_word(OP_INS_REAR, rand_word());
        send_word(OP_INS_FRONT, rand_word());
    endtask

    // random walks over a series of capacities and pacing modes
    task automatic test_random_walk();
        logic [CAP_W-1:0] cap_plan [RANDOM_PHASES];
        cap_plan = '{CAP_W'(1), CAP_W'(2), '0, CAP_W'(3), CAP_W'(8), CAP_ALL_ONES,
                     CAP_W'(5), CAP_W'(16), CAP_RESET, CAP_W'(4)};
        cap_plan[RANDOM_PHASES-1] = CAP_W'($urandom_range(64, 4));
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_capacity(cap_plan[p]);
            in_gaps  = (p % 4 == 0) || (p % 4 == 2);
            out_gaps = (p % 4 == 0) || (p % 4 == 3);
            for (int n = 0; n < RANDOM_WORDS / RANDOM_PHASES; n++)
                send_word(pick_random_op(), rand_word());
        end
    endtask

    // test sequence
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_deque();
        test_saturated_capacity();
        test_basic_operations();
        test_small_capacity();
        test_capacity_below_count();
        test_random_walk();
        wait_idle();
        $display("sent %0d words, %0d of them refused or unused codes, over %0d capacity writes",
                 words_sent, refused_words, cap_writes);
        $display("checked %0d result words across zero, small, lowered and saturated capacities",
                 results_seen);
        if (fail_count == 0) begin
            $display("tb_bounded_double_ended_queue: PASS");
        end else begin
            $display("tb_bounded_double_ended_queue: FAIL");
        end
        $finish;
    end

endmodule
